@@ rtl/core/fcba_pkg.sv @@
// Package for the chain block allocator.
// Holds command and status codes and the chain entry encoding; no dependencies.
package fcba_pkg;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FIND  = 2'd1,
        CMD_FREE  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOSPACE  = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_BADBLOCK = 3'd3,
        ST_DIRFULL  = 3'd4,
        ST_ZERO     = 3'd5
    } t_status;

    // Chain entry codes: two top bits mark end and free, otherwise a block number.
    localparam logic [1:0] MK_LINK = 2'b00;
    localparam logic [1:0] MK_END  = 2'b01;
    localparam logic [1:0] MK_FREE = 2'b11;

endpackage

@@ rtl/core/fat_chain_block_allocator.sv @@
// Allocate scans the chain table for free blocks, skipping used entries; find and
// free scan the directory, then follow the chain; an unknown command, or a find or
// free with an empty directory, goes straight to the result.
// Throughput: one request at a time, set by the walk; the next request is taken
// the cycle after the result is registered, even while that result waits.
// Reset: synchronous active low; a clearing pass then marks all chain entries
// free, during which no request is accepted.
module fat_chain_block_allocator
    import fcba_pkg::*;
#(
    parameter int BLOCK_BYTES = 32,
    parameter int DISK_BYTES  = 16384,
    parameter int DIR_ENTRIES = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [63:0] i_name_key,
    input  logic [14:0] i_byte_length,
    input  logic [8:0]  i_block_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [8:0]  o_block_number,
    output logic [9:0]  o_block_count
);

    localparam int NBLK = DISK_BYTES / BLOCK_BYTES;
    localparam int BW   = (NBLK > 1) ? $clog2(NBLK) : 1;
    localparam int CW   = $clog2(NBLK + 1);
    localparam int DW   = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
    localparam int DCW  = $clog2(DIR_ENTRIES + 1);
    localparam int EW   = BW + 2;

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_SIZE  = 10'b0000000100,
        S_SCAN  = 10'b0000001000,
        S_ALLOC = 10'b0000010000,
        S_DRD   = 10'b0000100000,
        S_DCHK  = 10'b0001000000,
        S_WALK  = 10'b0010000000,
        S_MOVE  = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } t_state;

    // Chain table memory: one port, registered read.
    logic [EW-1:0] m_chain [NBLK];
    logic [EW-1:0] r_chain_q;
    logic          c_we;
    logic [BW-1:0] c_addr;
    logic [EW-1:0] c_wd;

    // Directory memories.
    logic [63:0]   m_dkey [DIR_ENTRIES];
    logic [BW-1:0] m_dst  [DIR_ENTRIES];
    logic [63:0]   r_dkey_q;
    logic [BW-1:0] r_dst_q;
    logic          d_we;
    logic [DW-1:0] d_addr;
    logic [63:0]   d_wkey;
    logic [BW-1:0] d_wst;

    t_state r_state, n_state;
    t_cmd          r_cmd;
    logic [63:0]   r_key;
    logic [14:0]   r_len;
    logic [8:0]    r_idx;
    logic [CW-1:0] r_cnt, r_free;
    logic [BW-1:0] r_cur, r_prev, r_first;
    logic [DCW-1:0] r_dcnt, r_dpos;
    logic          r_rd;      // chain or directory read data is valid
    t_status       r_st;
    logic          r_ov;
    logic [2:0]    r_os;
    logic [8:0]    r_ob;
    logic [9:0]    r_oc;

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_ov;
    assign o_status       = r_os;
    assign o_block_number = r_ob;
    assign o_block_count  = r_oc;

    // Memory ports.
    always_ff @(posedge i_clk) begin
        if (c_we) m_chain[c_addr] <= c_wd;
        r_chain_q <= m_chain[c_addr];
        if (d_we) begin
            m_dkey[d_addr] <= d_wkey;
            m_dst[d_addr]  <= d_wst;
        end
        r_dkey_q <= m_dkey[d_addr];
        r_dst_q  <= m_dst[d_addr];
    end

    logic q_free, q_link, walk_on, need_more, emit;
    assign q_free = (r_chain_q[EW-1:EW-2] == MK_FREE);
    assign q_link = (r_chain_q[EW-1:EW-2] == MK_LINK) && (int'(r_chain_q[BW-1:0]) < NBLK);
    assign walk_on = q_link && !q_free && (int'(r_cnt) + 1 < NBLK);
    // More blocks are needed while the blocks taken hold fewer bytes than asked.
    assign need_more = (int'(r_cnt) * BLOCK_BYTES) < int'(r_len);
    assign emit = (r_state == S_DONE) && (!r_ov || i_ready);

    // Size and directory checks of an allocate request.
    t_status size_st;
    always_comb begin
        if (r_len == 0) size_st = ST_ZERO;
        else if (int'(r_len) > int'(r_free) * BLOCK_BYTES) size_st = ST_NOSPACE;
        else if (int'(r_dcnt) >= DIR_ENTRIES) size_st = ST_DIRFULL;
        else size_st = ST_OK;
    end

    // Result register: set when a result is ready, cleared when it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit) begin
            r_ov <= 1'b1;
        end else if (r_ov && i_ready) begin
            r_ov <= 1'b0;
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cur   <= '0;
            r_free  <= CW'(NBLK);
            r_dcnt  <= '0;
            r_rd    <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_CLEAR: begin
                    r_cur <= r_cur + 1'b1;
                end
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_cmd   <= t_cmd'(i_command);
                        r_key   <= i_name_key;
                        r_len   <= i_byte_length;
                        r_idx   <= i_block_index;
                        r_cnt   <= '0;
                        r_dpos  <= '0;
                        r_cur   <= '0;
                        r_prev  <= '0;
                        r_rd    <= 1'b0;
                        r_first <= '0;
                        if ((t_cmd'(i_command) == CMD_FIND || t_cmd'(i_command) == CMD_FREE)
                            && r_dcnt == 0)
                            r_st <= ST_NOTFOUND;
                        else
                            r_st <= ST_OK;
                    end
                end
                S_SIZE: begin
                    r_st <= size_st;
                end
                S_SCAN: begin
                    // Data for r_cur is valid while r_rd is high.
                    if (!r_rd) begin
                        r_rd <= 1'b1;
                    end else if (q_free) begin
                        r_rd  <= 1'b0;
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == 0) begin
                            r_first <= r_cur;
                            r_dcnt  <= r_dcnt + 1'b1;
                        end
                    end else if (int'(r_cur) == NBLK - 1) begin
                        r_rd <= 1'b0;
                        if (r_cnt == 0) r_st <= ST_NOSPACE;
                    end else begin
                        r_cur <= r_cur + 1'b1;
                    end
                end
                S_ALLOC: begin
                    r_prev <= r_cur;
                    r_cur  <= r_cur + 1'b1;
                end
                S_DCHK: begin
                    if (r_dkey_q == r_key) begin
                        r_cur   <= r_dst_q;
                        r_first <= r_dst_q;
                    end else if (r_dpos + 1'b1 >= r_dcnt) begin
                        r_st <= ST_NOTFOUND;
                    end else begin
                        r_dpos <= r_dpos + 1'b1;
                    end
                end
                S_WALK: begin
                    if (!r_rd) begin
                        r_rd <= 1'b1;
                    end else begin
                        r_rd <= 1'b0;
                        if (r_cmd == CMD_FIND) begin
                            if (!q_link) r_st <= ST_BADBLOCK;
                            else begin
                                r_cur <= r_chain_q[BW-1:0];
                                r_idx <= r_idx - 1'b1;
                            end
                        end else begin
                            if (!q_free) r_cnt <= r_cnt + 1'b1;
                            if (walk_on) r_cur <= r_chain_q[BW-1:0];
                        end
                    end
                end
                S_MOVE: begin
                    if (!r_rd) begin
                        r_rd <= 1'b1;
                    end else begin
                        r_rd   <= 1'b0;
                        r_dcnt <= r_dcnt - 1'b1;
                    end
                end
                S_DONE: begin
                    if (emit) begin
                        r_os <= r_st;
                        if (r_st == ST_OK && r_cmd != CMD_NONE) begin
                            r_ob <= 9'(r_cmd == CMD_FIND ? r_cur : r_first);
                            r_oc <= (r_cmd == CMD_FIND) ? 10'd0 : 10'(r_cnt);
                            if (r_cmd == CMD_ALLOC)
                                r_free <= (r_free >= r_cnt) ? r_free - r_cnt : '0;
                            else if (r_cmd == CMD_FREE)
                                r_free <= (int'(r_free) + int'(r_cnt) > NBLK) ? CW'(NBLK) :
                                          CW'(int'(r_free) + int'(r_cnt));
                        end else begin
                            r_ob <= '0;
                            r_oc <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Next state and memory controls.
    always_comb begin
        n_state = r_state;
        c_we = 1'b0; c_addr = r_cur; c_wd = '0;
        d_we = 1'b0; d_addr = r_dpos[DW-1:0]; d_wkey = r_key; d_wst = r_cur;
        case (r_state)
            S_CLEAR: begin
                c_we = 1'b1; c_wd = {MK_FREE, {BW{1'b0}}};
                if (int'(r_cur) == NBLK - 1) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    case (t_cmd'(i_command))
                        CMD_ALLOC: n_state = S_SIZE;
                        CMD_FIND, CMD_FREE:
                            n_state = (r_dcnt == 0) ? S_DONE : S_DRD;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_SIZE: begin
                n_state = (size_st == ST_OK) ? S_SCAN : S_DONE;
            end
            S_SCAN: begin
                if (r_rd) begin
                    if (q_free) begin
                        // Claim the block as end of chain; the link follows next cycle.
                        c_we = 1'b1; c_wd = {MK_END, {BW{1'b0}}};
                        n_state = S_ALLOC;
                        if (r_cnt == 0) begin
                            d_we = 1'b1; d_addr = r_dcnt[DW-1:0];
                        end
                    end else if (int'(r_cur) == NBLK - 1) begin
                        n_state = S_DONE;
                    end else begin
                        // Fetch the following entry so that its data is ready next cycle.
                        c_addr = r_cur + 1'b1;
                    end
                end
            end
            S_ALLOC: begin
                // Point the previous tail at the block just claimed.
                if (r_cnt > 1) begin
                    c_we = 1'b1; c_addr = r_prev; c_wd = {MK_LINK, r_cur};
                end
                n_state = (!need_more || int'(r_cur) == NBLK - 1) ? S_DONE : S_SCAN;
            end
            S_DRD: n_state = S_DCHK;
            S_DCHK: begin
                if (r_dkey_q == r_key) begin
                    if (r_cmd == CMD_FIND && r_idx == 0) n_state = S_DONE;
                    else n_state = S_WALK;
                end else if (r_dpos + 1'b1 >= r_dcnt) n_state = S_DONE;
                else n_state = S_DRD;
            end
            S_WALK: begin
                if (r_rd) begin
                    if (r_cmd == CMD_FIND) begin
                        if (!q_link || r_idx == 1) n_state = S_DONE;
                    end else begin
                        if (!q_free) begin
                            c_we = 1'b1; c_wd = {MK_FREE, {BW{1'b0}}};
                        end
                        if (!walk_on) n_state = S_MOVE;
                    end
                end
            end
            S_MOVE: begin
                // Read the last entry, then write it into the gap.
                d_addr = DW'(r_dcnt - 1'b1);
                if (r_rd) begin
                    d_we = 1'b1; d_addr = r_dpos[DW-1:0];
                    d_wkey = r_dkey_q; d_wst = r_dst_q;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (emit) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_free) <= NBLK) else $error("free count above block total");
    a_dir_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_dcnt) <= DIR_ENTRIES) else $error("directory count overflow");
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> o_valid) else $error("result not raised");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("ready while busy");
`endif

endmodule
